### design/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/snm_pkg.sv
package snm_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int IN_FRAC = DATA_WIDTH - 4;
  localparam int PROD_FRAC = 2 * IN_FRAC;
  localparam int SPAN_BITS = PROD_FRAC + 4;
  localparam int ACT_WIDTH = 16;
  localparam int ENTRY_WIDTH = 17;
  localparam int ACC_WIDTH_DEF = 40;
  localparam int TABLE_BITS_DEF = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_BIAS,
    ST_CLAMP,
    ST_RD_LO,
    ST_RD_HI,
    ST_INTERP,
    ST_EMIT
  } snm_state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic bias;
    logic clamp;
    logic rd_lo;
    logic rd_hi;
    logic interp;
    logic emit;
  } snm_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } snm_status_t;

  // restoring divide, used only while building the constant table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // rounded sigmoid sample i of a table with 2^tb+1 points over [-8, 8]
  function automatic logic [ENTRY_WIDTH-1:0] sig_entry(input int tb, input int i);
    logic [63:0] step;
    logic [63:0] term;
    logic [63:0] base;
    logic [63:0] pw;
    logic [63:0] den;
    logic [63:0] s;
    logic signed [63:0] sum;
    int half;
    int k;
    step = 64'd1 << (34 - tb);
    term = 64'd1 << 30;
    sum = 64'sd1 <<< 30;
    // e^-step by taylor series in q30
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * step) >> 30, 64'(n));
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    base = 64'(sum);
    half = 1 << (tb - 1);
    if (i == half) begin
      return ENTRY_WIDTH'(32768);
    end
    k = (i > half) ? (i - half) : (half - i);
    pw = 64'd1 << 30;
    for (int j = 1; j <= k; j++) begin
      pw = (pw * base + (64'd1 << 29)) >> 30;
    end
    den = (64'd1 << 30) + pw;
    s = udiv64((64'd1 << 46) + (den >> 1), den);
    if (i > half) begin
      return ENTRY_WIDTH'(s);
    end
    return ENTRY_WIDTH'(64'd65536 - s);
  endfunction

endpackage

### design/snm_ctrl.sv
module snm_ctrl
  import snm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  snm_status_t status,
  output snm_cmd_t    cmd
);

  snm_state_t state;
  snm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_MUL;
      end
      ST_MUL:    state_next = ST_ACC;
      ST_ACC:    state_next = status.last ? ST_BIAS : ST_IDLE;
      ST_BIAS:   state_next = ST_CLAMP;
      ST_CLAMP:  state_next = ST_RD_LO;
      ST_RD_LO:  state_next = ST_RD_HI;
      ST_RD_HI:  state_next = ST_INTERP;
      ST_INTERP: state_next = ST_EMIT;
      ST_EMIT: begin
        // hold until the output register can take the result
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_MUL:    cmd.mul = 1'b1;
      ST_ACC:    cmd.acc = 1'b1;
      ST_BIAS:   cmd.bias = 1'b1;
      ST_CLAMP:  cmd.clamp = 1'b1;
      ST_RD_LO:  cmd.rd_lo = 1'b1;
      ST_RD_HI:  cmd.rd_hi = 1'b1;
      ST_INTERP: cmd.interp = 1'b1;
      ST_EMIT:   cmd.emit = !status.out_busy;
      default:   cmd = '0;
    endcase
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_emit_holds, clk, rst, state == ST_EMIT && status.out_busy, state == ST_EMIT)
  `ASSERT_NEXT(a_last_goes_bias, clk, rst, state == ST_ACC && status.last, state == ST_BIAS && !s_tready)

endmodule

### design/snm_datapath.sv
module snm_datapath
  import snm_pkg::*;
#(
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [2*DATA_WIDTH-1:0] s_tdata,
  input  logic                    s_tlast,
  input  logic                    cfg_valid,
  input  logic [DATA_WIDTH-1:0]   cfg_data,
  input  snm_cmd_t                cmd,
  output snm_status_t             status,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [ACT_WIDTH-1:0]    m_tdata,
  output logic                    m_tuser
);

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int SUM_W = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
  localparam int CMP_W = ((ACC_WIDTH > SPAN_BITS) ? ACC_WIDTH : SPAN_BITS) + 1;
  localparam int FRAC_BITS = SPAN_BITS - TABLE_BITS;
  localparam int FRAC_KEEP = (FRAC_BITS > 24) ? 24 : FRAC_BITS;
  localparam int TAB_SIZE = (1 << TABLE_BITS) + 1;
  localparam int ADDR_W = TABLE_BITS + 1;
  localparam int PART_W = ENTRY_WIDTH + FRAC_KEEP;
  localparam int MIX_W = ENTRY_WIDTH + 1;

  localparam logic signed [SUM_W-1:0] ACC_MAX_EXT =
    {{(SUM_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN_EXT = ~ACC_MAX_EXT;
  localparam logic signed [CMP_W-1:0] LIM = CMP_W'(1) <<< (PROD_FRAC + 3);
  localparam logic [PART_W-1:0] ROUND_HALF = PART_W'(1) << (FRAC_KEEP - 1);

  logic signed [DATA_WIDTH-1:0]   x_q;
  logic signed [DATA_WIDTH-1:0]   w_q;
  logic                           last_q;
  logic signed [DATA_WIDTH-1:0]   bias;
  logic signed [PROD_W-1:0]       prod;
  logic signed [PROD_W-1:0]       bias_scaled;
  logic signed [ACC_WIDTH-1:0]    acc;
  logic signed [ACC_WIDTH-1:0]    sum;
  logic signed [SUM_W-1:0]        addend;
  logic signed [SUM_W-1:0]        sum_raw;
  logic signed [ACC_WIDTH-1:0]    sat_val;
  logic signed [CMP_W-1:0]        sum_ext;
  logic signed [CMP_W-1:0]        shifted;
  logic [SPAN_BITS-1:0]           u;
  logic                           clip;
  logic [TABLE_BITS-1:0]          idx;
  logic [FRAC_KEEP-1:0]           frac;
  logic [ADDR_W-1:0]              rd_addr;
  logic [ENTRY_WIDTH-1:0]         rom [TAB_SIZE];
  logic [ENTRY_WIDTH-1:0]         lo;
  logic [ENTRY_WIDTH-1:0]         hi;
  logic [PART_W-1:0]              part;
  logic [MIX_W-1:0]               act_full;
  logic                           out_valid;
  logic [ACT_WIDTH-1:0]           act_q;
  logic                           clip_q;

  // constant sigmoid samples
  for (genvar g = 0; g < TAB_SIZE; g++) begin : g_rom
    localparam logic [ENTRY_WIDTH-1:0] ENTRY = sig_entry(TABLE_BITS, g);
    assign rom[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (cfg_valid) begin
      bias <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_q    <= s_tdata[DATA_WIDTH-1:0];
      w_q    <= s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
      last_q <= s_tlast;
    end
    if (cmd.mul) begin
      prod <= x_q * w_q;
    end
  end

  assign bias_scaled = PROD_W'(bias) <<< IN_FRAC;
  assign addend = cmd.bias ? SUM_W'(bias_scaled) : SUM_W'(prod);
  assign sum_raw = SUM_W'(acc) + addend;

  // saturate at the accumulator range
  always_comb begin
    if (sum_raw > ACC_MAX_EXT) begin
      sat_val = ACC_MAX_EXT[ACC_WIDTH-1:0];
    end else if (sum_raw < ACC_MIN_EXT) begin
      sat_val = ACC_MIN_EXT[ACC_WIDTH-1:0];
    end else begin
      sat_val = sum_raw[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.acc) begin
      acc <= sat_val;
    end else if (cmd.bias) begin
      acc <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bias) begin
      sum <= sat_val;
    end
  end

  // clamp to [-8, 8) and move to an offset from -8
  assign sum_ext = CMP_W'(sum);
  assign shifted = sum_ext + LIM;

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      if (sum_ext < -LIM) begin
        u    <= '0;
        clip <= 1'b1;
      end else if (sum_ext >= LIM) begin
        u    <= '1;
        clip <= 1'b1;
      end else begin
        u    <= shifted[SPAN_BITS-1:0];
        clip <= 1'b0;
      end
    end
  end

  assign idx = u[SPAN_BITS-1 -: TABLE_BITS];
  assign frac = u[FRAC_BITS-1 -: FRAC_KEEP];
  assign rd_addr = cmd.rd_hi ? (ADDR_W'(idx) + ADDR_W'(1)) : ADDR_W'(idx);

  always_ff @(posedge clk) begin
    if (cmd.rd_lo) begin
      lo <= rom[rd_addr];
    end
    if (cmd.rd_hi) begin
      hi <= rom[rd_addr];
    end
    if (cmd.interp) begin
      part <= PART_W'(hi - lo) * PART_W'(frac);
    end
  end

  assign act_full = MIX_W'(lo) + MIX_W'((part + ROUND_HALF) >> FRAC_KEEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      act_q  <= (act_full > MIX_W'(65535)) ? '1 : act_full[ACT_WIDTH-1:0];
      clip_q <= clip;
    end
  end

  assign status.last = last_q;
  assign status.out_busy = out_valid && !m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata = act_q;
  assign m_tuser = clip_q;

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_acc_cleared, clk, rst, cmd.bias, acc == '0)
  `ASSERT_IMPL(a_table_rising, clk, rst, cmd.interp, hi >= lo)
  `ASSERT_NEXT(a_emit_shows, clk, rst, cmd.emit, m_tvalid)

endmodule

### design/sigmoid_neuron_mac.sv
// single neuron: multiply-accumulate followed by a sigmoid activation
// input stream s_*: one request carries an input value and its weight
// (s_tdata, signed q4.12 each) and s_tlast marks the final pair of a vector
// each pair passes capture, multiply and accumulate into a saturating
// q16.24 accumulator; a new pair is taken only once the last one is done
// a pair with s_tlast set then goes on through bias add, clamp, two reads of
// the sigmoid table through its single port, interpolation multiply and
// output load, which stalls while an earlier result still waits for m_tready
// output stream m_*: activation as unsigned q0.16 in m_tdata, m_tuser high
// when the sum was clamped to [-8, 8); pairs without s_tlast give no result
// a waiting result sits in the output register, and further pairs are still
// accumulated meanwhile; only the next result waits for m_tready
// cfg_*: bias write, signed q4.12, always ready; write only while idle
// reset (rst, synchronous) clears the accumulator, the bias and the output
// valid; the table is constant and needs no fill
module sigmoid_neuron_mac
  import snm_pkg::*;
#(
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [2*DATA_WIDTH-1:0] s_tdata,   // in_value, weight
  input  logic                    s_tlast,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [ACT_WIDTH-1:0]    m_tdata,   // activation
  output logic                    m_tuser,   // clamped
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [DATA_WIDTH-1:0]   cfg_data   // bias
);

  snm_cmd_t    cmd;
  snm_status_t status;

  assign cfg_ready = 1'b1;

  snm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  snm_datapath #(
    .ACC_WIDTH  (ACC_WIDTH),
    .TABLE_BITS (TABLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
